>>> rtl/core/rlcd_pkg.sv
package rlcd_pkg;

    localparam int NUM_KW    = 6;
    localparam int KW_MAX    = 7;
    localparam int MAX_RES   = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W     = $clog2(MAX_RES + 1);
    localparam int CODE_W    = 31;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;

    localparam logic [CODE_W-1:0] CODE_MAX   = {CODE_W{1'b1}};
    localparam logic [CODE_W-1:0] FAULT_BELOW = CODE_W'(100);

    typedef enum logic [2:0] {
        MODE_KEYWORD = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_SKIPSP  = 3'd2,
        MODE_RAW     = 3'd3,
        MODE_DATA    = 3'd4,
        MODE_CODE    = 3'd5,
        MODE_DROP    = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        KIND_DATA    = 3'd0,
        KIND_OK      = 3'd1,
        KIND_ERR     = 3'd2,
        KIND_INQ     = 3'd3,
        KIND_STATUS  = 3'd4,
        KIND_END     = 3'd5,
        KIND_INVALID = 3'd6
    } t_kind;

    typedef struct packed {
        logic              is_payload;
        logic [7:0]        out_byte;
        t_kind             line_kind;
        logic              last;
        logic [CODE_W-1:0] error_number;
        logic              server_fault;
    } t_result;

    // keyword table: D, S, OK, ERR, INQUIRE, END
    localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
        '{8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h45, 8'h52, 8'h52, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h4E, 8'h51, 8'h55, 8'h49, 8'h52, 8'h45},
        '{8'h45, 8'h4E, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [NUM_KW] = '{4'd1, 4'd1, 4'd2, 4'd3, 4'd7, 4'd3};
    localparam t_kind KW_KIND [NUM_KW] =
        '{KIND_DATA, KIND_STATUS, KIND_OK, KIND_ERR, KIND_INQ, KIND_END};

    function automatic logic [7:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= CH_9) begin
            v = c - CH_0;
        end else if (c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end else begin
            v = c - CH_LA + 8'd10;
        end
        return v;
    endfunction

    function automatic t_result mk_res(input logic pay, input logic [7:0] b,
                                       input t_kind kind, input logic last,
                                       input logic [CODE_W-1:0] num,
                                       input logic fault);
        t_result r;
        r.is_payload   = pay;
        r.out_byte     = b;
        r.line_kind    = kind;
        r.last         = last;
        r.error_number = num;
        r.server_fault = fault;
        return r;
    endfunction

endpackage

>>> rtl/core/rlcd_in_if.sv
interface rlcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink (input valid, input byte_value, output ready);
endinterface

>>> rtl/core/rlcd_out_if.sv
interface rlcd_out_if;
    logic        valid;
    logic        ready;
    logic        is_payload;
    logic [7:0]  out_byte;
    logic [2:0]  line_kind;
    logic        last;
    logic [30:0] error_number;
    logic        server_fault;

    modport source (output valid, output is_payload, output out_byte, output line_kind,
                    output last, output error_number, output server_fault, input ready);
    modport sink (input valid, input is_payload, input out_byte, input line_kind,
                  input last, input error_number, input server_fault, output ready);
endinterface

>>> rtl/core/response_line_classifier_decoder.sv
// channel | dir | payload                                          | beat
// i_in    | in  | byte_value                                       | one received byte
// o_out   | out | is_payload, out_byte, line_kind, last,           | one payload byte
//         |     | error_number, server_fault                       | or line summary
// one byte per cycle while i_in.ready is high: input register, parse logic, then an 8-entry result queue
// a byte's result goes from the input register through the parse logic into the queue; o_out shows the queue head
// a newline may put up to three beats in the queue; the queue drains one beat per cycle while o_out.ready is high
// i_in.ready drops while the queue holds more than two beats
// i_rst_n clears the parser to the start of a line and empties the queue
module response_line_classifier_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rlcd_in_if.sink           i_in,
    rlcd_out_if.source        o_out
);

    logic                         r_in_valid;
    logic [7:0]                   r_in_byte;

    logic [3:0]                   r_pos, n_pos;
    logic [rlcd_pkg::NUM_KW-1:0]  r_mask, n_mask;
    rlcd_pkg::t_mode              r_mode, n_mode;
    rlcd_pkg::t_kind              r_kind, n_kind;
    logic [1:0]                   r_esc, n_esc;
    logic [7:0]                   r_held, n_held;
    logic [rlcd_pkg::CODE_W-1:0]  r_acc, n_acc;
    logic [1:0]                   r_phase, n_phase;
    logic                         r_neg, n_neg;
    logic                         n_clear;

    rlcd_pkg::t_result            n_res [rlcd_pkg::MAX_RES];
    logic [rlcd_pkg::RES_W-1:0]   n_num;

    rlcd_pkg::t_result            r_fifo [rlcd_pkg::FIFO_DEPTH];
    logic [rlcd_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [rlcd_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [rlcd_pkg::CNT_W-1:0]   r_count;

    rlcd_pkg::t_result            w_head;
    logic                         w_accept;
    logic                         w_pop;

    assign w_accept    = i_in.valid & i_in.ready;
    assign w_pop       = o_out.valid & o_out.ready;
    assign i_in.ready  = r_count <=
        rlcd_pkg::CNT_W'(rlcd_pkg::FIFO_DEPTH - 2 * rlcd_pkg::MAX_RES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
        if (w_accept) begin
            r_in_byte <= i_in.byte_value;
        end
    end

    // parse logic
    always_comb begin
        logic [7:0]                  b;
        logic [rlcd_pkg::NUM_KW-1:0] alive;
        logic                        hit;
        logic [2:0]                  hit_idx;
        rlcd_pkg::t_kind             end_kind;
        logic [1:0]                  idx;
        logic                        digit;
        logic                        ws;
        logic [rlcd_pkg::CODE_W+3:0] acc10;
        logic [rlcd_pkg::CODE_W-1:0] num;
        logic                        fault;
        logic [7:0]                  hi_nib;
        logic [7:0]                  lo_nib;

        n_pos   = r_pos;
        n_mask  = r_mask;
        n_mode  = r_mode;
        n_kind  = r_kind;
        n_esc   = r_esc;
        n_held  = r_held;
        n_acc   = r_acc;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_clear = 1'b0;
        n_num   = '0;
        for (int k = 0; k < rlcd_pkg::MAX_RES; k++) begin
            n_res[k] = '0;
        end

        b        = r_in_byte;
        alive    = '0;
        hit      = 1'b0;
        hit_idx  = '0;
        end_kind = rlcd_pkg::KIND_INVALID;
        idx      = '0;
        digit    = (b >= rlcd_pkg::CH_0) && (b <= rlcd_pkg::CH_9);
        ws       = (b == rlcd_pkg::CH_SPACE) ||
                   ((b >= rlcd_pkg::CH_TAB) && (b <= rlcd_pkg::CH_CR));
        acc10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                   (rlcd_pkg::CODE_W+4)'(b - rlcd_pkg::CH_0);
        num      = '0;
        fault    = 1'b0;
        hi_nib   = rlcd_pkg::hex_nibble(r_held);
        lo_nib   = rlcd_pkg::hex_nibble(b);

        for (int i = 1; i < rlcd_pkg::NUM_KW; i++) begin
            if (r_mask[i] && (r_pos == rlcd_pkg::KW_LEN[i])) begin
                end_kind = rlcd_pkg::KW_KIND[i];
            end
        end

        if (r_in_valid) begin
            if (b == rlcd_pkg::CH_NL) begin
                if ((r_mode == rlcd_pkg::MODE_COMMENT) ||
                    ((r_mode == rlcd_pkg::MODE_KEYWORD) && (r_pos == 4'd0))) begin
                    n_clear = 1'b1;
                end else begin
                    if (r_mode != rlcd_pkg::MODE_KEYWORD) begin
                        end_kind = r_kind;
                    end
                    if ((r_mode == rlcd_pkg::MODE_DATA) && (r_esc >= 2'd1)) begin
                        n_res[idx] = rlcd_pkg::mk_res(1'b1, rlcd_pkg::CH_PERCENT, end_kind,
                                                      1'b0, '0, 1'b0);
                        idx = idx + 2'd1;
                    end
                    if ((r_mode == rlcd_pkg::MODE_DATA) && (r_esc >= 2'd2)) begin
                        n_res[idx] = rlcd_pkg::mk_res(1'b1, r_held, end_kind,
                                                      1'b0, '0, 1'b0);
                        idx = idx + 2'd1;
                    end
                    if (end_kind == rlcd_pkg::KIND_ERR) begin
                        num   = r_neg ? '0 : r_acc;
                        fault = r_neg || (r_acc < rlcd_pkg::FAULT_BELOW);
                    end
                    n_res[idx] = rlcd_pkg::mk_res(1'b0, 8'd0, end_kind, 1'b1, num, fault);
                    n_num   = rlcd_pkg::RES_W'(idx) + rlcd_pkg::RES_W'(1);
                    n_clear = 1'b1;
                end
            end else begin
                unique case (r_mode)
                    rlcd_pkg::MODE_KEYWORD: begin
                        if ((r_pos == 4'd0) && (b == rlcd_pkg::CH_HASH)) begin
                            n_mode = rlcd_pkg::MODE_COMMENT;
                        end else begin
                            for (int i = 0; i < rlcd_pkg::NUM_KW; i++) begin
                                if (r_mask[i] && !hit) begin
                                    if (r_pos < rlcd_pkg::KW_LEN[i]) begin
                                        if (b == rlcd_pkg::KW_TEXT[i][r_pos[2:0]]) begin
                                            alive[i] = 1'b1;
                                        end
                                    end else if (r_pos == rlcd_pkg::KW_LEN[i]) begin
                                        if ((b == rlcd_pkg::CH_SPACE) ||
                                            ((b == rlcd_pkg::CH_NUL) && (i != 0))) begin
                                            hit     = 1'b1;
                                            hit_idx = 3'(i);
                                        end
                                    end
                                end
                            end
                            if (hit) begin
                                n_kind = rlcd_pkg::KW_KIND[hit_idx];
                                if (b == rlcd_pkg::CH_NUL) begin
                                    n_mode = rlcd_pkg::MODE_DROP;
                                end else begin
                                    case (rlcd_pkg::KW_KIND[hit_idx])
                                        rlcd_pkg::KIND_DATA: n_mode = rlcd_pkg::MODE_DATA;
                                        rlcd_pkg::KIND_ERR:  n_mode = rlcd_pkg::MODE_CODE;
                                        rlcd_pkg::KIND_END:  n_mode = rlcd_pkg::MODE_DROP;
                                        default:             n_mode = rlcd_pkg::MODE_SKIPSP;
                                    endcase
                                end
                            end else begin
                                n_mask = alive;
                                if (r_pos != 4'd15) begin
                                    n_pos = r_pos + 4'd1;
                                end
                                if (alive == '0) begin
                                    n_kind = rlcd_pkg::KIND_INVALID;
                                    n_mode = rlcd_pkg::MODE_DROP;
                                end
                            end
                        end
                    end
                    rlcd_pkg::MODE_SKIPSP: begin
                        if (b == rlcd_pkg::CH_NUL) begin
                            n_mode = rlcd_pkg::MODE_DROP;
                        end else if (b != rlcd_pkg::CH_SPACE) begin
                            n_mode   = rlcd_pkg::MODE_RAW;
                            n_res[0] = rlcd_pkg::mk_res(1'b1, b, r_kind, 1'b0, '0, 1'b0);
                            n_num    = rlcd_pkg::RES_W'(1);
                        end
                    end
                    rlcd_pkg::MODE_RAW: begin
                        if (b == rlcd_pkg::CH_NUL) begin
                            n_mode = rlcd_pkg::MODE_DROP;
                        end else begin
                            n_res[0] = rlcd_pkg::mk_res(1'b1, b, r_kind, 1'b0, '0, 1'b0);
                            n_num    = rlcd_pkg::RES_W'(1);
                        end
                    end
                    rlcd_pkg::MODE_DATA: begin
                        if (r_esc == 2'd0) begin
                            if (b == rlcd_pkg::CH_PERCENT) begin
                                n_esc = 2'd1;
                            end else begin
                                n_res[0] = rlcd_pkg::mk_res(1'b1, b, r_kind, 1'b0, '0, 1'b0);
                                n_num    = rlcd_pkg::RES_W'(1);
                            end
                        end else if (r_esc == 2'd1) begin
                            n_held = b;
                            n_esc  = 2'd2;
                        end else begin
                            n_esc    = 2'd0;
                            n_res[0] = rlcd_pkg::mk_res(1'b1,
                                {hi_nib[3:0], 4'b0} + lo_nib, r_kind, 1'b0, '0, 1'b0);
                            n_num    = rlcd_pkg::RES_W'(1);
                        end
                    end
                    rlcd_pkg::MODE_CODE: begin
                        if (b == rlcd_pkg::CH_NUL) begin
                            n_phase = 2'd3;
                            n_mode  = rlcd_pkg::MODE_DROP;
                        end else if ((r_phase == 2'd0) && ws) begin
                            n_phase = r_phase;
                        end else if ((r_phase == 2'd0) &&
                                     ((b == rlcd_pkg::CH_PLUS) || (b == rlcd_pkg::CH_MINUS))) begin
                            n_neg   = (b == rlcd_pkg::CH_MINUS);
                            n_phase = 2'd1;
                        end else if ((r_phase != 2'd3) && digit) begin
                            if (acc10 > {4'b0, rlcd_pkg::CODE_MAX}) begin
                                n_acc = rlcd_pkg::CODE_MAX;
                            end else begin
                                n_acc = acc10[rlcd_pkg::CODE_W-1:0];
                            end
                            n_phase = 2'd2;
                        end else begin
                            n_phase = 2'd3;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || n_clear) begin
            r_pos   <= '0;
            r_mask  <= '1;
            r_mode  <= rlcd_pkg::MODE_KEYWORD;
            r_kind  <= rlcd_pkg::KIND_DATA;
            r_esc   <= '0;
            r_held  <= '0;
            r_acc   <= '0;
            r_phase <= '0;
            r_neg   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_mask  <= n_mask;
            r_mode  <= n_mode;
            r_kind  <= n_kind;
            r_esc   <= n_esc;
            r_held  <= n_held;
            r_acc   <= n_acc;
            r_phase <= n_phase;
            r_neg   <= n_neg;
        end
    end

    // result queue
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < rlcd_pkg::MAX_RES; k++) begin
            if (rlcd_pkg::RES_W'(k) < n_num) begin
                r_fifo[r_wr_ptr + rlcd_pkg::PTR_W'(k)] <= n_res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + rlcd_pkg::PTR_W'(n_num);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + rlcd_pkg::PTR_W'(1);
            end
            r_count <= r_count + rlcd_pkg::CNT_W'(n_num) - rlcd_pkg::CNT_W'(w_pop);
        end
    end

    assign w_head             = r_fifo[r_rd_ptr];
    assign o_out.valid        = r_count != '0;
    assign o_out.is_payload   = w_head.is_payload;
    assign o_out.out_byte     = w_head.out_byte;
    assign o_out.line_kind    = w_head.line_kind;
    assign o_out.last         = w_head.last;
    assign o_out.error_number = w_head.error_number;
    assign o_out.server_fault = w_head.server_fault;

endmodule

>>> sim/rlcd_line_checker.sv
`timescale 1ns / 1ps
module rlcd_line_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_out_is_payload,
    input  logic [7:0]  i_out_byte,
    input  logic [2:0]  i_out_line_kind,
    input  logic        i_out_last,
    input  logic [30:0] i_out_error_number,
    input  logic        i_out_server_fault,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int KEY_COUNT = 6;

    // D, S, OK, ERR, INQUIRE, END
    localparam logic [7:0] KEY_CHARS [KEY_COUNT][7] = '{
        '{"D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"E", "R", "R", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "N", "Q", "U", "I", "R", "E"},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [3:0] KEY_LEN [KEY_COUNT] = '{4'd1, 4'd1, 4'd2, 4'd3, 4'd7, 4'd3};
    localparam rlcd_pkg::t_kind KEY_KIND [KEY_COUNT] = '{
        rlcd_pkg::KIND_DATA, rlcd_pkg::KIND_STATUS, rlcd_pkg::KIND_OK,
        rlcd_pkg::KIND_ERR, rlcd_pkg::KIND_INQ, rlcd_pkg::KIND_END
    };

    typedef enum logic [1:0] {
        ERRP_LEAD   = 2'd0,
        ERRP_SIGN   = 2'd1,
        ERRP_DIGITS = 2'd2,
        ERRP_STOP   = 2'd3
    } t_err_phase;

    logic [3:0]                  kw_pos;
    logic [5:0]                  kw_alive;
    rlcd_pkg::t_mode             mode;
    rlcd_pkg::t_kind             line_kind_q;
    logic [1:0]                  esc_cnt;
    logic [7:0]                  esc_hi;
    logic [rlcd_pkg::CODE_W-1:0] err_acc;
    t_err_phase                  err_phase;
    logic                        err_neg;

    rlcd_pkg::t_result expected_results[$];
    int                mismatch_count = 0;
    int                pending_beats = 0;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending_beats;

    task automatic start_line();
        kw_pos      = '0;
        kw_alive    = '1;
        mode        = rlcd_pkg::MODE_KEYWORD;
        line_kind_q = rlcd_pkg::KIND_DATA;
        esc_cnt     = '0;
        esc_hi      = '0;
        err_acc     = '0;
        err_phase   = ERRP_LEAD;
        err_neg     = 1'b0;
    endtask

    task automatic queue_payload(input logic [7:0] b, input rlcd_pkg::t_kind k);
        expected_results.push_back(rlcd_pkg::mk_res(1'b1, b, k, 1'b0, '0, 1'b0));
    endtask

    function automatic logic [7:0] nibble_value(input logic [7:0] c);
        if (c <= rlcd_pkg::CH_9) begin
            return c - rlcd_pkg::CH_0;
        end else if (c <= rlcd_pkg::CH_UF) begin
            return c - rlcd_pkg::CH_UA + 8'd10;
        end
        return c - rlcd_pkg::CH_LA + 8'd10;
    endfunction

    task automatic accept_keyword(input rlcd_pkg::t_kind k, input logic [7:0] b);
        line_kind_q = k;
        if (b == rlcd_pkg::CH_NUL) begin
            mode = rlcd_pkg::MODE_DROP;
        end else begin
            case (k)
                rlcd_pkg::KIND_DATA: begin
                    mode = rlcd_pkg::MODE_DATA;
                end
                rlcd_pkg::KIND_ERR: begin
                    mode      = rlcd_pkg::MODE_CODE;
                    err_phase = ERRP_LEAD;
                end
                rlcd_pkg::KIND_END: begin
                    mode = rlcd_pkg::MODE_DROP;
                end
                default: begin
                    mode = rlcd_pkg::MODE_SKIPSP;
                end
            endcase
        end
    endtask

    task automatic keyword_step(input logic [7:0] b);
        logic [5:0] next_alive;
        if (kw_pos == 4'd0 && b == rlcd_pkg::CH_HASH) begin
            mode = rlcd_pkg::MODE_COMMENT;
            return;
        end
        next_alive = '0;
        for (int i = 0; i < KEY_COUNT; i++) begin
            if (kw_alive[i]) begin
                if (kw_pos < KEY_LEN[i]) begin
                    if (b == KEY_CHARS[i][kw_pos[2:0]]) begin
                        next_alive[i] = 1'b1;
                    end
                end else if (kw_pos == KEY_LEN[i] &&
                             (b == rlcd_pkg::CH_SPACE ||
                              (b == rlcd_pkg::CH_NUL && i != 0))) begin
                    accept_keyword(KEY_KIND[i], b);
                    return;
                end
            end
        end
        kw_alive = next_alive;
        if (kw_pos != 4'd15) begin
            kw_pos = kw_pos + 4'd1;
        end
        if (next_alive == '0) begin
            line_kind_q = rlcd_pkg::KIND_INVALID;
            mode        = rlcd_pkg::MODE_DROP;
        end
    endtask

    task automatic err_code_step(input logic [7:0] b);
        logic [31:0] d;
        if (err_phase == ERRP_LEAD) begin
            if (b == rlcd_pkg::CH_SPACE || (b >= rlcd_pkg::CH_TAB && b <= rlcd_pkg::CH_CR)) begin
                return;
            end
            if (b == rlcd_pkg::CH_PLUS || b == rlcd_pkg::CH_MINUS) begin
                err_neg   = (b == rlcd_pkg::CH_MINUS);
                err_phase = ERRP_SIGN;
                return;
            end
        end
        if (err_phase != ERRP_STOP && b >= rlcd_pkg::CH_0 && b <= rlcd_pkg::CH_9) begin
            d = 32'(b - rlcd_pkg::CH_0);
            if (32'(err_acc) > (32'(rlcd_pkg::CODE_MAX) - d) / 32'd10) begin
                err_acc = rlcd_pkg::CODE_MAX;
            end else begin
                err_acc = rlcd_pkg::CODE_W'(32'(err_acc) * 32'd10 + d);
            end
            err_phase = ERRP_DIGITS;
            return;
        end
        err_phase = ERRP_STOP;
    endtask

    task automatic finish_line();
        rlcd_pkg::t_kind             k;
        logic [rlcd_pkg::CODE_W-1:0] num;
        logic                        fault;
        k     = line_kind_q;
        num   = '0;
        fault = 1'b0;
        if (mode == rlcd_pkg::MODE_COMMENT) begin
            start_line();
            return;
        end
        if (mode == rlcd_pkg::MODE_KEYWORD) begin
            if (kw_pos == 4'd0) begin
                start_line();
                return;
            end
            k = rlcd_pkg::KIND_INVALID;
            for (int i = 1; i < KEY_COUNT; i++) begin
                if (kw_alive[i] && kw_pos == KEY_LEN[i]) begin
                    k = KEY_KIND[i];
                end
            end
        end
        if (mode == rlcd_pkg::MODE_DATA) begin
            if (esc_cnt >= 2'd1) begin
                queue_payload(rlcd_pkg::CH_PERCENT, k);
            end
            if (esc_cnt >= 2'd2) begin
                queue_payload(esc_hi, k);
            end
        end
        if (k == rlcd_pkg::KIND_ERR) begin
            num   = err_neg ? '0 : err_acc;
            fault = err_neg || (err_acc < rlcd_pkg::FAULT_BELOW);
        end
        expected_results.push_back(rlcd_pkg::mk_res(1'b0, 8'h00, k, 1'b1, num, fault));
        start_line();
    endtask

    task automatic predict_byte(input logic [7:0] b);
        if (b == rlcd_pkg::CH_NL) begin
            finish_line();
            return;
        end
        case (mode)
            rlcd_pkg::MODE_KEYWORD: begin
                keyword_step(b);
            end
            rlcd_pkg::MODE_SKIPSP: begin
                if (b == rlcd_pkg::CH_NUL) begin
                    mode = rlcd_pkg::MODE_DROP;
                end else if (b != rlcd_pkg::CH_SPACE) begin
                    mode = rlcd_pkg::MODE_RAW;
                    queue_payload(b, line_kind_q);
                end
            end
            rlcd_pkg::MODE_RAW: begin
                if (b == rlcd_pkg::CH_NUL) begin
                    mode = rlcd_pkg::MODE_DROP;
                end else begin
                    queue_payload(b, line_kind_q);
                end
            end
            rlcd_pkg::MODE_DATA: begin
                if (esc_cnt == 2'd0) begin
                    if (b == rlcd_pkg::CH_PERCENT) begin
                        esc_cnt = 2'd1;
                    end else begin
                        queue_payload(b, line_kind_q);
                    end
                end else if (esc_cnt == 2'd1) begin
                    esc_hi  = b;
                    esc_cnt = 2'd2;
                end else begin
                    esc_cnt = 2'd0;
                    queue_payload(8'(nibble_value(esc_hi) << 4) + nibble_value(b),
                                  line_kind_q);
                end
            end
            rlcd_pkg::MODE_CODE: begin
                if (b == rlcd_pkg::CH_NUL) begin
                    err_phase = ERRP_STOP;
                    mode      = rlcd_pkg::MODE_DROP;
                end else begin
                    err_code_step(b);
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        rlcd_pkg::t_result got;
        rlcd_pkg::t_result want;
        if (!i_rst_n) begin
            start_line();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = rlcd_pkg::mk_res(i_out_is_payload, i_out_byte,
                                       rlcd_pkg::t_kind'(i_out_line_kind), i_out_last,
                                       i_out_error_number, i_out_server_fault);
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display({"unexpected beat: pay=%0d byte=%02h kind=%0d last=%0d",
                                  " err=%0d fault=%0d"},
                                 got.is_payload, got.out_byte, got.line_kind, got.last,
                                 got.error_number, got.server_fault);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatch_count < 10) begin
                            $display({"mismatch: exp pay=%0d byte=%02h kind=%0d last=%0d",
                                      " err=%0d fault=%0d"},
                                     want.is_payload, want.out_byte, want.line_kind,
                                     want.last, want.error_number, want.server_fault);
                            $display({"          got pay=%0d byte=%02h kind=%0d last=%0d",
                                      " err=%0d fault=%0d"},
                                     got.is_payload, got.out_byte, got.line_kind,
                                     got.last, got.error_number, got.server_fault);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_byte);
            end
        end
        pending_beats = expected_results.size();
    end

endmodule

>>> sim/tb_response_line_classifier_decoder.sv
`timescale 1ns / 1ps
module tb_response_line_classifier_decoder;

    logic  clk = 1'b0;
    logic  rst_n;
    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    bytes_sent = 0;
    int    fail_count;
    int    pending_count;
    string keyword_text [6] = '{"D", "S", "OK", "ERR", "INQUIRE", "END"};
    string hex_digits = "0123456789ABCDEFabcdef";

    rlcd_in_if  in_ch ();
    rlcd_out_if out_ch ();

    response_line_classifier_decoder u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    rlcd_line_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_ch.valid),
        .i_in_ready         (in_ch.ready),
        .i_in_byte          (in_ch.byte_value),
        .i_out_valid        (out_ch.valid),
        .i_out_ready        (out_ch.ready),
        .i_out_is_payload   (out_ch.is_payload),
        .i_out_byte         (out_ch.out_byte),
        .i_out_line_kind    (out_ch.line_kind),
        .i_out_last         (out_ch.last),
        .i_out_error_number (out_ch.error_number),
        .i_out_server_fault (out_ch.server_fault),
        .o_fail_count       (fail_count),
        .o_pending          (pending_count)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("tb_response_line_classifier_decoder: FAIL");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.byte_value <= b;
        do begin
            @(posedge clk);
        end while (!in_ch.ready);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == rlcd_pkg::CH_NL);
        return b;
    endfunction

    function automatic logic [7:0] hex_char();
        if ($urandom_range(3) == 0) begin
            return rand_text_byte();
        end
        return hex_digits[$urandom_range(21)];
    endfunction

    task automatic send_plain(input int n);
        repeat (n) begin
            send_byte(($urandom_range(15) == 0) ? rlcd_pkg::CH_NUL : rand_text_byte());
        end
    endtask

    task automatic send_data_body();
        int tail;
        repeat ($urandom_range(0, 10)) begin
            if ($urandom_range(9) < 3) begin
                send_byte(rlcd_pkg::CH_PERCENT);
                send_byte(hex_char());
                send_byte(hex_char());
            end else begin
                send_byte(rand_text_byte());
            end
        end
        // escape cut short by the newline
        tail = $urandom_range(9);
        if (tail < 2) begin
            send_byte(rlcd_pkg::CH_PERCENT);
        end
        if (tail == 1) begin
            send_byte(hex_char());
        end
    endtask

    task automatic send_code_body();
        logic [7:0] b;
        int         n;
        repeat ($urandom_range(0, 2)) begin
            b = ($urandom_range(3) == 0) ? rlcd_pkg::CH_SPACE : 8'($urandom_range(9, 13));
            send_byte((b == rlcd_pkg::CH_NL) ? rlcd_pkg::CH_TAB : b);
        end
        case ($urandom_range(9))
            0: send_byte(rlcd_pkg::CH_PLUS);
            1, 2: send_byte(rlcd_pkg::CH_MINUS);
            default: begin
            end
        endcase
        n = ($urandom_range(4) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 4);
        repeat (n) begin
            send_byte(8'(rlcd_pkg::CH_0 + $urandom_range(9)));
        end
        if ($urandom_range(3) == 0) begin
            send_plain($urandom_range(1, 3));
        end
    endtask

    task automatic send_random_line();
        int         pick;
        int         sep;
        int         kw;
        int         n;
        logic [7:0] b;
        string      word;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 8)) begin
                send_byte(8'($urandom_range(255)));
            end
        end else if (pick < 12) begin
        end else if (pick < 17) begin
            send_byte(rlcd_pkg::CH_HASH);
            send_plain($urandom_range(0, 6));
        end else if (pick < 25) begin
            // truncated or corrupted keyword
            word = keyword_text[$urandom_range(5)];
            n = $urandom_range(word.len());
            for (int i = 0; i < n; i++) begin
                b = word[i];
                if ($urandom_range(3) == 0) begin
                    b = rand_text_byte();
                end
                send_byte(b);
            end
            if ($urandom_range(1) == 1) begin
                send_byte(rlcd_pkg::CH_SPACE);
                send_plain($urandom_range(0, 4));
            end
        end else begin
            kw = $urandom_range(5);
            send_text(keyword_text[kw]);
            sep = $urandom_range(9);
            if (sep == 7) begin
                send_byte(rlcd_pkg::CH_NUL);
                send_plain($urandom_range(0, 3));
            end else if (sep == 9) begin
                send_byte(rand_text_byte());
                send_plain($urandom_range(0, 3));
            end else if (sep != 8) begin
                repeat ((sep < 5) ? 1 : $urandom_range(2, 3)) begin
                    send_byte(rlcd_pkg::CH_SPACE);
                end
                case (kw)
                    0: send_data_body();
                    3: send_code_body();
                    5: send_plain($urandom_range(0, 1) * $urandom_range(0, 4));
                    default: send_plain($urandom_range(0, 8));
                endcase
            end
        end
        send_byte(rlcd_pkg::CH_NL);
    endtask

    initial begin
        int target;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.byte_value = 8'h00;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 19;
                    recv_idle_pct = 84;
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 19;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p == 0) begin
                send_byte(rlcd_pkg::CH_NL);
                send_byte(rlcd_pkg::CH_HASH);
                send_byte(rlcd_pkg::CH_NL);
                send_text("OK");
                send_byte(rlcd_pkg::CH_NL);
                send_text("D %4g%");
                send_byte(rlcd_pkg::CH_NL);
                send_text("ERR -7");
                send_byte(rlcd_pkg::CH_NL);
                send_text("S ");
                send_byte(8'hFF);
                send_byte(rlcd_pkg::CH_NUL);
                send_byte(rlcd_pkg::CH_NL);
                send_text("END");
                send_byte(rlcd_pkg::CH_NL);
            end
            target = (p + 1) * 87;
            while (bytes_sent < target) begin
                send_random_line();
            end
        end
        in_ch.valid <= 1'b0;
        while (pending_count != 0) begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb_response_line_classifier_decoder: PASS");
        end else begin
            $display("tb_response_line_classifier_decoder: FAIL");
        end
        $finish;
    end

endmodule
